### sv/frame_bitmap_allocator_assert.svh
// Assertion helpers for the frame bitmap allocator.
// Bodies use the module's clock and reset.
`ifndef FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_ASSERT_SVH

// cond must hold in the same cycle as ante
`define FBA_ASSERT_IMPLY(lbl, ante, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cond)) \
      else $error(msg);

// cond must hold in the cycle after ante
`define FBA_ASSERT_NEXT(lbl, ante, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cond)) \
      else $error(msg);

// cond must never be seen
`define FBA_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

### sv/fba_pkg.sv
`timescale 1ns / 1ps
package fba_pkg;

   localparam int WORD_BITS  = 64;
   localparam int LOG_WORD   = 6;
   localparam int IDX_W      = 13;
   localparam int ADDR_W     = 32;
   localparam int PAGE_SHIFT = 12;

   localparam logic [ADDR_W-1:0] LOW_LIMIT       = 32'h0010_0000;
   localparam logic [IDX_W-1:0]  FRAME_COUNT_RST = 13'd3840;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_INIT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK     = 2'd0,
      STS_NOMEM  = 2'd1,
      STS_DOUBLE = 2'd2,
      STS_RANGE  = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      REG_FRAME_COUNT = 1'b0,
      REG_RESERVED    = 1'b1
   } reg_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_MARK,
      S_FREE_RD,
      S_FREE_WR,
      S_INIT,
      S_DONE
   } state_type;

   // per-word result of the first-fit search
   typedef struct packed {
      logic                carry_hit;   // run from earlier words reaches length here
      logic                inside_hit;  // run fits wholly inside this word
      logic [LOG_WORD-1:0] inside_pos;
      logic                any_used;
      logic [LOG_WORD-1:0] last_used;
   } word_scan_type;

endpackage

### sv/fba_map_ram.sv
`timescale 1ns / 1ps
module fba_map_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [fba_pkg::WORD_BITS-1:0] rd_data,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [fba_pkg::WORD_BITS-1:0] wr_data
);
   import fba_pkg::*;

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read-before-write on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/fba_run_find.sv
`timescale 1ns / 1ps
module fba_run_find (
   input  logic [fba_pkg::WORD_BITS-1:0] word_free,
   input  logic [fba_pkg::IDX_W-1:0]     run_len,
   input  logic [fba_pkg::IDX_W-1:0]     run_carry,
   output fba_pkg::word_scan_type        scan
);
   import fba_pkg::*;

   logic [WORD_BITS-1:0] used;
   logic [WORD_BITS-1:0] span [LOG_WORD];
   logic [WORD_BITS-1:0] starts;
   logic [LOG_WORD-1:0]  first_used;
   logic [LOG_WORD:0]    lead;
   logic                 short_len;

   // span[k] bit i: 2**k free frames start at i
   always_comb begin
      span[0] = word_free;
      for (int k = 1; k < LOG_WORD; k++) begin
         span[k] = span[k-1] & (span[k-1] >> (1 << (k - 1)));
      end
   end

   always_comb begin
      used = ~word_free;
      scan.any_used = |used;

      first_used = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (used[i]) first_used = LOG_WORD'(i);
      end
      scan.last_used = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (used[i]) scan.last_used = LOG_WORD'(i);
      end

      lead = scan.any_used ? {1'b0, first_used} : (LOG_WORD + 1)'(WORD_BITS);
      scan.carry_hit = ({1'b0, run_carry} + (IDX_W + 1)'(lead)) >= {1'b0, run_len};

      // compose the run length from its binary digits
      starts = '1;
      for (int b = 0; b < LOG_WORD; b++) begin
         if (run_len[b]) begin
            starts = starts &
                     (span[b] >> (run_len[LOG_WORD-1:0] & LOG_WORD'((1 << b) - 1)));
         end
      end
      short_len = (run_len >> LOG_WORD) == '0;
      scan.inside_hit = short_len && (run_len != '0) && (|starts);

      scan.inside_pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (starts[i]) scan.inside_pos = LOG_WORD'(i);
      end
   end

endmodule

### sv/frame_bitmap_allocator.sv
`timescale 1ns / 1ps
// Alloc and alloc-run: 64-frame words are read up to the first fitting run (at most
//    ceil(min(frame_count, FRAME_SLOTS)/64)), then the words the run covers are read and rewritten.
// Free reads its map word and writes it back; reinitialize rewrites every map word.
// Throughput: one item at a time; the scan moves 64 frames per cycle through the map RAM port.
// Reset (synchronous): control cleared, frame count set to 3840, reserved to 0, then a clearing pass
//    writes all FRAME_SLOTS/64 map words, one per cycle, before the first item is taken (csr writes ok).
`include "frame_bitmap_allocator_assert.svh"
module frame_bitmap_allocator #(
   parameter int FRAME_SLOTS = 4096
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_command,
   input  logic [fba_pkg::IDX_W-1:0]    req_run_length,
   input  logic [fba_pkg::ADDR_W-1:0]   req_free_address,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [fba_pkg::ADDR_W-1:0]   rsp_frame_address,
   output logic [1:0]                   rsp_status,
   output logic [fba_pkg::IDX_W-1:0]    rsp_frames_in_use,

   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [2:0]                   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import fba_pkg::*;

   // map geometry: one RAM word holds 64 frame bits
   localparam int WORDS  = (FRAME_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CW     = WA_W + 1;                         // word counters reach WORDS
   localparam int SLOT_W = $clog2(FRAME_SLOTS + 1);
   localparam int CMP_W  = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
   localparam int SW     = (CW + LOG_WORD > IDX_W + 1) ? CW + LOG_WORD : IDX_W + 1;

   // ---------------------------------------------------------------- state
   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [IDX_W-1:0]     len_ff, len_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic [CW-1:0]        rd_w_ff, rd_w_in;          // next word to read / sweep
   logic                 pv_ff, pv_in;              // a read is returning this cycle
   logic [WA_W-1:0]      pv_w_ff, pv_w_in;          // word that read belongs to
   logic [IDX_W-1:0]     run_ff, run_in;            // free frames carried into next word
   logic [IDX_W-1:0]     run_start_ff, run_start_in;
   logic [IDX_W-1:0]     mk_s_ff, mk_s_in;          // run being marked: first frame
   logic [IDX_W-1:0]     mk_e_ff, mk_e_in;          // and last frame
   logic [IDX_W-1:0]     init_r_ff, init_r_in;      // frames set by the sweep
   logic [IDX_W-1:0]     used_total_ff, used_total_in;
   status_type           res_status_ff, res_status_in;
   logic [IDX_W-1:0]     frame_count_ff, frame_count_in;
   logic [IDX_W-1:0]     reserved_ff, reserved_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]     rsp_fiu_ff, rsp_fiu_in;

   // ---------------------------------------------------------------- map RAM
   logic                 mem_rd_en;
   logic [WA_W-1:0]      mem_rd_addr;
   logic [WORD_BITS-1:0] mem_rd_data;
   logic                 mem_wr_en;
   logic [WA_W-1:0]      mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;

   fba_map_ram #(
      .DEPTH (WORDS),
      .AW    (WA_W)
   ) u_map (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // ---------------------------------------------------------------- decode
   logic                 accept;
   cmd_type              req_cmd;
   logic                 cnt_lt;
   logic [IDX_W-1:0]     live_cnt;
   logic [CW-1:0]        live_words;
   logic                 alloc_fail;
   logic                 below_low;
   logic [ADDR_W-1:0]    free_off;
   logic [ADDR_W-PAGE_SHIFT-1:0] free_n;
   logic                 free_out;
   logic [IDX_W-1:0]     init_r_now;
   logic                 rsp_free;

   assign req_cmd  = cmd_type'(req_command);
   assign req_stall = (state_ff != S_IDLE);
   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // frames actually managed: frame_count clamped to the map size
   assign cnt_lt     = CMP_W'(frame_count_ff) < CMP_W'(FRAME_SLOTS);
   assign live_cnt   = cnt_lt ? frame_count_ff : IDX_W'(FRAME_SLOTS);
   assign live_words = CW'(((IDX_W + 1)'(live_cnt) + (IDX_W + 1)'(WORD_BITS - 1)) >> LOG_WORD);

   assign alloc_fail = (live_cnt == '0) || ((req_cmd == CMD_RUN) && (req_run_length == '0));

   assign below_low = req_free_address < LOW_LIMIT;
   assign free_off  = req_free_address - LOW_LIMIT;
   assign free_n    = free_off[ADDR_W-1:PAGE_SHIFT];
   assign free_out  = below_low || (free_n >= (ADDR_W - PAGE_SHIFT)'(live_cnt));

   assign init_r_now = (reserved_ff < live_cnt) ? reserved_ff : live_cnt;

   // ---------------------------------------------------------------- scan path
   logic [IDX_W-1:0]     scan_base;
   logic                 scan_last;
   logic [WORD_BITS-1:0] valid_mask;
   logic [WORD_BITS-1:0] word_free;
   word_scan_type        scan;
   logic                 scan_hit;
   logic [IDX_W-1:0]     scan_start;

   assign scan_base = IDX_W'({pv_w_ff, {LOG_WORD{1'b0}}});
   assign scan_last = ({1'b0, pv_w_ff} + CW'(1)) == live_words;

   // frames at or beyond the live count look used
   always_comb begin
      valid_mask = '1;
      if (scan_last && (live_cnt[LOG_WORD-1:0] != '0)) begin
         valid_mask = (WORD_BITS'(1) << live_cnt[LOG_WORD-1:0]) - WORD_BITS'(1);
      end
   end

   assign word_free = ~mem_rd_data & valid_mask;

   fba_run_find u_find (
      .word_free (word_free),
      .run_len   (len_ff),
      .run_carry (run_ff),
      .scan      (scan)
   );

   assign scan_hit   = scan.carry_hit || scan.inside_hit;
   assign scan_start = scan.carry_hit ? run_start_ff
                                      : scan_base + IDX_W'(scan.inside_pos);

   // ---------------------------------------------------------------- mark path
   logic [CW-1:0]        ws_w, we_w;
   logic [LOG_WORD-1:0]  mark_lo, mark_hi;
   logic [WORD_BITS-1:0] mark_mask;
   logic                 mark_last;

   assign ws_w      = CW'(mk_s_ff >> LOG_WORD);
   assign we_w      = CW'(mk_e_ff >> LOG_WORD);
   assign mark_lo   = ({1'b0, pv_w_ff} == ws_w) ? mk_s_ff[LOG_WORD-1:0] : '0;
   assign mark_hi   = ({1'b0, pv_w_ff} == we_w) ? mk_e_ff[LOG_WORD-1:0] : '1;
   assign mark_mask = ({WORD_BITS{1'b1}} << mark_lo) &
                      ({WORD_BITS{1'b1}} >> (LOG_WORD'(WORD_BITS - 1) - mark_hi));
   assign mark_last = ({1'b0, pv_w_ff} == we_w);

   // ---------------------------------------------------------------- sweep path
   logic [SW-1:0]        sw_base, sw_r;
   logic [WORD_BITS-1:0] sweep_word;
   logic                 sweep_last;

   assign sw_base    = SW'({rd_w_ff, {LOG_WORD{1'b0}}});
   assign sw_r       = SW'(init_r_ff);
   assign sweep_last = (rd_w_ff == CW'(WORDS - 1));

   // word gets ones for every frame below init_r
   always_comb begin
      if (sw_base + SW'(WORD_BITS) <= sw_r) begin
         sweep_word = '1;
      end else if (sw_base >= sw_r) begin
         sweep_word = '0;
      end else begin
         sweep_word = (WORD_BITS'(1) << init_r_ff[LOG_WORD-1:0]) - WORD_BITS'(1);
      end
   end

   // ---------------------------------------------------------------- free path
   logic                 freed_bit;

   assign freed_bit = mem_rd_data[free_idx_ff[LOG_WORD-1:0]];

   // ---------------------------------------------------------------- FSM next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_cmd) inside
                  CMD_ALLOC, CMD_RUN: state_in = alloc_fail ? S_DONE : S_SCAN;
                  CMD_FREE:           state_in = free_out ? S_DONE : S_FREE_RD;
                  CMD_INIT:           state_in = S_INIT;
                  default:            state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (pv_ff && scan_hit) begin
               state_in = S_MARK;
            end else if (pv_ff && scan_last) begin
               state_in = S_DONE;
            end
         end
         S_MARK: begin
            if (pv_ff && mark_last) state_in = S_DONE;
         end
         S_FREE_RD: state_in = S_FREE_WR;
         S_FREE_WR: state_in = S_DONE;
         S_INIT: begin
            if (sweep_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- FSM outputs
   always_comb begin
      cmd_in        = cmd_ff;
      len_in        = len_ff;
      free_idx_in   = free_idx_ff;
      rd_w_in       = rd_w_ff;
      pv_in         = 1'b0;
      pv_w_in       = pv_w_ff;
      run_in        = run_ff;
      run_start_in  = run_start_ff;
      mk_s_in       = mk_s_ff;
      mk_e_in       = mk_e_ff;
      init_r_in     = init_r_ff;
      used_total_in = used_total_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fiu_in    = rsp_fiu_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = rd_w_ff[WA_W-1:0];
      mem_wr_en     = 1'b0;
      mem_wr_addr   = rd_w_ff[WA_W-1:0];
      mem_wr_data   = sweep_word;

      unique case (state_ff)
         S_CLEAR, S_INIT: begin
            mem_wr_en = 1'b1;
            rd_w_in   = rd_w_ff + CW'(1);
            if (sweep_last && (state_ff == S_INIT)) begin
               used_total_in = init_r_ff;
               res_status_in = STS_OK;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in        = req_cmd;
               len_in        = (req_cmd == CMD_ALLOC) ? IDX_W'(1) : req_run_length;
               free_idx_in   = free_n[IDX_W-1:0];
               init_r_in     = init_r_now;
               rd_w_in       = '0;
               run_in        = '0;
               run_start_in  = '0;
               res_status_in = STS_OK;
               if ((req_cmd == CMD_ALLOC || req_cmd == CMD_RUN) && alloc_fail) begin
                  res_status_in = STS_NOMEM;
               end
               if ((req_cmd == CMD_FREE) && free_out) begin
                  res_status_in = STS_RANGE;
               end
            end
         end
         S_SCAN: begin
            // one word issued per cycle, checked the cycle after
            if (rd_w_ff < live_words) begin
               mem_rd_en = 1'b1;
               pv_in     = 1'b1;
               pv_w_in   = rd_w_ff[WA_W-1:0];
               rd_w_in   = rd_w_ff + CW'(1);
            end
            if (pv_ff) begin
               if (scan_hit) begin
                  pv_in   = 1'b0;
                  mk_s_in = scan_start;
                  mk_e_in = scan_start + len_ff - IDX_W'(1);
                  rd_w_in = CW'(scan_start >> LOG_WORD);
               end else begin
                  if (scan.any_used) begin
                     run_in       = IDX_W'(LOG_WORD'(WORD_BITS - 1) - scan.last_used);
                     run_start_in = scan_base + IDX_W'(scan.last_used) + IDX_W'(1);
                  end else begin
                     run_in = run_ff + IDX_W'(WORD_BITS);
                  end
                  if (scan_last) res_status_in = STS_NOMEM;
               end
            end
         end
         S_MARK: begin
            // read-modify-write over the words the run covers
            if (rd_w_ff <= we_w) begin
               mem_rd_en = 1'b1;
               pv_in     = 1'b1;
               pv_w_in   = rd_w_ff[WA_W-1:0];
               rd_w_in   = rd_w_ff + CW'(1);
            end
            if (pv_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pv_w_ff;
               mem_wr_data = mem_rd_data | mark_mask;
               if (mark_last) begin
                  pv_in         = 1'b0;
                  used_total_in = used_total_ff + len_ff;
                  res_status_in = STS_OK;
               end
            end
         end
         S_FREE_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = WA_W'(free_idx_ff >> LOG_WORD);
         end
         S_FREE_WR: begin
            mem_wr_addr = WA_W'(free_idx_ff >> LOG_WORD);
            mem_wr_data = mem_rd_data &
                          ~(WORD_BITS'(1) << free_idx_ff[LOG_WORD-1:0]);
            if (freed_bit) begin
               mem_wr_en     = 1'b1;
               used_total_in = used_total_ff - IDX_W'(1);
               res_status_in = STS_OK;
            end else begin
               res_status_in = STS_DOUBLE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_fiu_in    = used_total_ff;
               rsp_addr_in   = '0;
               if ((res_status_ff == STS_OK) &&
                   (cmd_ff == CMD_ALLOC || cmd_ff == CMD_RUN)) begin
                  rsp_addr_in = LOW_LIMIT +
                     {{(ADDR_W - IDX_W - PAGE_SHIFT){1'b0}}, mk_s_ff, {PAGE_SHIFT{1'b0}}};
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   // ---------------------------------------------------------------- CSR
   logic    csr_wr;
   reg_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      frame_count_in = frame_count_ff;
      reserved_in    = reserved_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_FRAME_COUNT: frame_count_in = csr_pwdata[IDX_W-1:0];
            REG_RESERVED:    reserved_in    = csr_pwdata[IDX_W-1:0];
            default:         frame_count_in = frame_count_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_FRAME_COUNT: csr_prdata = 32'(frame_count_ff);
         REG_RESERVED:    csr_prdata = 32'(reserved_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         rd_w_ff        <= '0;
         pv_ff          <= 1'b0;
         init_r_ff      <= '0;
         used_total_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         frame_count_ff <= FRAME_COUNT_RST;
         reserved_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         rd_w_ff        <= rd_w_in;
         pv_ff          <= pv_in;
         init_r_ff      <= init_r_in;
         used_total_ff  <= used_total_in;
         rsp_valid_ff   <= rsp_valid_in;
         frame_count_ff <= frame_count_in;
         reserved_ff    <= reserved_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      len_ff        <= len_in;
      free_idx_ff   <= free_idx_in;
      pv_w_ff       <= pv_w_in;
      run_ff        <= run_in;
      run_start_ff  <= run_start_in;
      mk_s_ff       <= mk_s_in;
      mk_e_ff       <= mk_e_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fiu_ff    <= rsp_fiu_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_frames_in_use = rsp_fiu_ff;

   // ---------------------------------------------------------------- checks
   `FBA_ASSERT_NEVER(a_no_write_idle,
      mem_wr_en && (state_ff == S_IDLE || state_ff == S_DONE),
      "map written while no command is active")
   `FBA_ASSERT_IMPLY(a_mark_span, (state_ff == S_MARK) && mem_wr_en,
      ({1'b0, pv_w_ff} >= ws_w) && ({1'b0, pv_w_ff} <= we_w),
      "mark write outside the allocated run")
   `FBA_ASSERT_IMPLY(a_scan_live, (state_ff == S_SCAN) && pv_ff,
      {1'b0, pv_w_ff} < live_words,
      "scan read beyond the live frames")
   `FBA_ASSERT_IMPLY(a_free_total, (state_ff == S_FREE_WR) && freed_bit,
      used_total_ff != '0,
      "used frame seen while the used count is zero")
   `FBA_ASSERT_NEXT(a_done_rsp, (state_ff == S_DONE) && rsp_free,
      rsp_valid_ff && (state_ff == S_IDLE),
      "result not presented after command end")

endmodule

### bench/frame_bitmap_allocator_tb.sv
`timescale 1ns / 1ps
module frame_bitmap_allocator_tb;
   import fba_pkg::*;

   localparam int FRAME_SLOTS     = 4096;
   localparam int FRAME_BYTES     = 4096;
   localparam int RESET_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 500;  // long receiver hold-off, fills the block
   localparam int DRAIN_CYCLES    = 16;   // quiet time after the last result
   // worst item is a full scan plus gaps and stalls; taken well over
   localparam int CYCLE_LIMIT     = 2000000;

   // one input item and one result item, at the block's widths
   typedef struct packed {
      cmd_type                command;
      logic [IDX_W-1:0]       run_length;
      logic [ADDR_W-1:0]      free_address;
   } frame_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]      frame_address;
      status_type             status;
      logic [IDX_W-1:0]       frames_in_use;
   } frame_rsp_type;

   // directed row: stimulus plus, where obvious, the typed-in answer
   typedef struct packed {
      frame_req_type          req;
      logic                   typed;
      frame_rsp_type          rsp;
   } directed_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_command;
   logic [IDX_W-1:0]    req_run_length;
   logic [ADDR_W-1:0]   req_free_address;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [ADDR_W-1:0]   rsp_frame_address;
   logic [1:0]          rsp_status;
   logic [IDX_W-1:0]    rsp_frames_in_use;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [2:0]          csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   // shadow of the allocator: used bit per frame, used count, registers
   bit                  frame_used [FRAME_SLOTS];
   int unsigned         frames_used;
   int unsigned         frame_count_q;
   int unsigned         reserved_q;

   frame_rsp_type       expected_results [$];
   directed_row_type    directed_rows [$];
   int unsigned         error_count;
   int unsigned         result_count;
   int unsigned         cycle_count;
   int unsigned         burst_left;
   bit                  hold_off_go;

   frame_bitmap_allocator #(
      .FRAME_SLOTS(FRAME_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_run_length(req_run_length),
      .req_free_address(req_free_address),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_frame_address(rsp_frame_address),
      .rsp_status(rsp_status),
      .rsp_frames_in_use(rsp_frames_in_use),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d results outstanding", cycle_count,
                  expected_results.size());
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR result %0d %s: got 0x%0h, wanted 0x%0h", result_count, what, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------------------------
   // Shadow allocator
   // ---------------------------------------------------------------------------------

   // frames actually managed: the register clamped to the map size
   function automatic int unsigned live_frames();
      return (frame_count_q < FRAME_SLOTS) ? frame_count_q : FRAME_SLOTS;
   endfunction

   function automatic logic [ADDR_W-1:0] frame_base_addr(int unsigned n);
      return LOW_LIMIT + (ADDR_W'(n) << PAGE_SHIFT);
   endfunction

   // applies one accepted item to the shadow and returns the answer it must give
   function automatic frame_rsp_type predict_frame_result(frame_req_type it);
      frame_rsp_type    r;
      int unsigned      live;
      int unsigned      n;
      int unsigned      k;
      int unsigned      run;
      int unsigned      start;
      int unsigned      keep;
      bit               found;
      logic [ADDR_W-1:0] offs;
      live = live_frames();
      r.frame_address = '0;
      r.status = STS_OK;
      found = 1'b0;
      case (it.command)
         CMD_ALLOC: begin
            r.status = STS_NOMEM;
            for (n = 0; n < live && !found; n++) begin
               if (!frame_used[n]) begin
                  frame_used[n] = 1'b1;
                  frames_used++;
                  r.frame_address = frame_base_addr(n);
                  r.status = STS_OK;
                  found = 1'b1;
               end
            end
         end
         CMD_RUN: begin
            // first fit; zero length never fits
            r.status = STS_NOMEM;
            run = 0;
            if (it.run_length != 0) begin
               for (n = 0; n < live && !found; n++) begin
                  if (frame_used[n]) begin
                     run = 0;
                  end else begin
                     run++;
                     if (run == it.run_length) begin
                        start = n + 1 - run;
                        for (k = start; k <= n; k++) begin
                           frame_used[k] = 1'b1;
                           frames_used++;
                        end
                        r.frame_address = frame_base_addr(start);
                        r.status = STS_OK;
                        found = 1'b1;
                     end
                  end
               end
            end
         end
         CMD_FREE: begin
            if (it.free_address < LOW_LIMIT) begin
               r.status = STS_RANGE;
            end else begin
               offs = (it.free_address - LOW_LIMIT) >> PAGE_SHIFT;
               if (offs >= live) begin
                  r.status = STS_RANGE;
               end else if (!frame_used[offs]) begin
                  r.status = STS_DOUBLE;
               end else begin
                  frame_used[offs] = 1'b0;
                  frames_used--;
               end
            end
         end
         default: begin
            // reinit: whole map cleared, reserved low frames (clamped) marked
            keep = (reserved_q < live) ? reserved_q : live;
            for (n = 0; n < FRAME_SLOTS; n++) frame_used[n] = (n < keep);
            frames_used = keep;
         end
      endcase
      r.frames_in_use = IDX_W'(frames_used);
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // Random items, shaped by the shadow map so frees mostly hit live frames
   // ---------------------------------------------------------------------------------
   function automatic frame_req_type random_request();
      frame_req_type    it;
      int unsigned      live;
      int unsigned      pick;
      int unsigned      sel;
      int unsigned      n;
      int unsigned      k;
      live = live_frames();
      // unused fields carry random bits too
      it.command = CMD_ALLOC;
      it.run_length = IDX_W'($urandom);
      it.free_address = $urandom;
      pick = $urandom_range(0, 99);
      sel = $urandom_range(0, 19);
      if (pick < 25) begin
         it.command = CMD_ALLOC;
      end else if (pick < 47) begin
         it.command = CMD_RUN;
         if (sel < 14) it.run_length = IDX_W'($urandom_range(1, 8));
         else if (sel < 17) it.run_length = IDX_W'($urandom_range(1, (live > 0) ? live : 1));
         else if (sel < 18) it.run_length = '0;
      end else if (pick < 95) begin
         it.command = CMD_FREE;
         if (sel < 14 && live > 0) begin
            // nearest used frame at or after a random spot, wrapping
            n = $urandom_range(0, live - 1);
            for (k = 0; k < live && !frame_used[n]; k++) n = (n + 1 == live) ? 0 : n + 1;
            it.free_address = frame_base_addr(n) + $urandom_range(0, FRAME_BYTES - 1);
         end else if (sel < 16 && live > 0) begin
            it.free_address = frame_base_addr($urandom_range(0, live - 1))
                              + $urandom_range(0, FRAME_BYTES - 1);
         end else if (sel < 18) begin
            it.free_address = $urandom_range(0, LOW_LIMIT - 1);
         end else if (sel < 19) begin
            it.free_address = frame_base_addr(live + $urandom_range(0, 63))
                              + $urandom_range(0, FRAME_BYTES - 1);
         end
      end else if (pick < 97) begin
         it.command = CMD_INIT;
      end else begin
         it.command = cmd_type'($urandom_range(0, 3));
      end
      return it;
   endfunction

   // ---------------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------------

   // offers one item from the next falling edge; valid stays high until taken
   task automatic send_item(frame_req_type it, logic typed, frame_rsp_type typed_rsp);
      frame_rsp_type p;
      @(negedge clock);
      req_valid = 1'b1;
      req_command = it.command;
      req_run_length = it.run_length;
      req_free_address = it.free_address;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted: shadow moves on now, so the next random pick sees it
      p = predict_frame_result(it);
      expected_results.push_back(typed ? typed_rsp : p);
   endtask

   task automatic idle_sender(int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
   endtask

   // bursts of random length; now and then a long burst with no gaps at all
   task automatic pace_sender();
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         idle_sender($urandom_range(1, 24));
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // sender pauses until every result is back, then a little longer
   task automatic wait_drained();
      idle_sender(1);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // Register port: setup cycle, access cycle; reads are checked against the shadow
   // ---------------------------------------------------------------------------------
   task automatic csr_access(logic is_write, reg_type r, logic [31:0] value);
      logic [31:0] want;
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = is_write;
      csr_paddr = {r, 2'b00};
      csr_pwdata = is_write ? value : 32'($urandom);
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (is_write) begin
         if (r == REG_FRAME_COUNT) frame_count_q = value[IDX_W-1:0];
         else reserved_q = value[IDX_W-1:0];
      end else begin
         want = (r == REG_FRAME_COUNT) ? frame_count_q : reserved_q;
         if (csr_prdata !== want) report_mismatch("register readback", csr_prdata, want);
      end
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_registers(int unsigned count, int unsigned reserved);
      csr_access(1'b1, REG_FRAME_COUNT, count);
      csr_access(1'b1, REG_RESERVED, reserved);
      csr_access(1'b0, REG_FRAME_COUNT, 0);
      csr_access(1'b0, REG_RESERVED, 0);
   endtask

   // one configuration, then a stream of random items; the map is kept across phases,
   // so a smaller count leaves stale used bits above it
   task automatic run_phase(int unsigned count, int unsigned reserved, int unsigned items,
                            bit hold_off);
      int unsigned   i;
      frame_rsp_type none;
      none = '0;
      wait_drained();
      set_registers(count, reserved);
      for (i = 0; i < items; i++) begin
         send_item(random_request(), 1'b0, none);
         // receiver holds off while the sender keeps offering
         if (hold_off && i == 0) hold_off_go = 1'b1;
         if (!(hold_off && i < 20)) pace_sender();
      end
   endtask

   task automatic add_row(cmd_type c, int unsigned len, logic [31:0] a, logic typed,
                          logic [31:0] want_addr, status_type want_status,
                          int unsigned want_used);
      directed_row_type row;
      row.req.command = c;
      row.req.run_length = IDX_W'(len);
      row.req.free_address = a;
      row.typed = typed;
      row.rsp.frame_address = want_addr;
      row.rsp.status = want_status;
      row.rsp.frames_in_use = IDX_W'(want_used);
      directed_rows.push_back(row);
   endtask

   // ---------------------------------------------------------------------------------
   // Receiver: its own stall pattern, plus the long hold-off on request
   // ---------------------------------------------------------------------------------
   initial begin : rsp_pacer
      int unsigned mode;
      int unsigned left;
      mode = 0;
      left = 50;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_go) begin
            rsp_stall = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_go = 1'b0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 200);
         end
         left--;
         case (mode)
            0: rsp_stall = 1'b0;
            1: rsp_stall = ($urandom_range(0, 3) == 0);
            2: rsp_stall = ~rsp_stall;
            default: rsp_stall = ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // result check, oldest expectation first
   always @(posedge clock) begin
      frame_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, address", rsp_frame_address, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_frame_address !== want.frame_address)
               report_mismatch("frame_address", rsp_frame_address, want.frame_address);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_frames_in_use !== want.frames_in_use)
               report_mismatch("frames_in_use", rsp_frames_in_use, want.frames_in_use);
         end
         result_count++;
      end
   end

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   initial begin : main_seq
      int unsigned i;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_ALLOC;
      req_run_length = '0;
      req_free_address = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      error_count = 0;
      result_count = 0;
      cycle_count = 0;
      burst_left = 1;
      hold_off_go = 1'b0;
      for (i = 0; i < FRAME_SLOTS; i++) frame_used[i] = 1'b0;
      frames_used = 0;
      frame_count_q = FRAME_COUNT_RST;
      reserved_q = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values of the registers
      csr_access(1'b0, REG_FRAME_COUNT, 0);
      csr_access(1'b0, REG_RESERVED, 0);

      // directed part, reset config: 3840 frames, nothing reserved
      add_row(CMD_ALLOC, 0, 32'h0000_0000, 1, 32'h0010_0000, STS_OK, 1);
      add_row(CMD_ALLOC, 8191, 32'hFFFF_FFFF, 1, 32'h0010_1000, STS_OK, 2);
      add_row(CMD_FREE, 0, 32'h0010_0000, 1, 32'h0, STS_OK, 1);
      add_row(CMD_FREE, 0, 32'h0010_0000, 1, 32'h0, STS_DOUBLE, 1);      // double free
      add_row(CMD_FREE, 0, 32'h0000_0000, 1, 32'h0, STS_RANGE, 1);       // below 1 MB
      add_row(CMD_FREE, 0, 32'h000F_FFFF, 1, 32'h0, STS_RANGE, 1);
      add_row(CMD_FREE, 0, 32'h0100_0000, 1, 32'h0, STS_RANGE, 1);       // first past count
      add_row(CMD_FREE, 0, 32'hFFFF_FFFF, 1, 32'h0, STS_RANGE, 1);
      add_row(CMD_RUN, 0, 32'h0, 1, 32'h0, STS_NOMEM, 1);                // zero length
      add_row(CMD_RUN, 8191, 32'h0, 1, 32'h0, STS_NOMEM, 1);             // far too long
      add_row(CMD_RUN, 3840, 32'h0, 1, 32'h0, STS_NOMEM, 1);             // one frame short
      add_row(CMD_ALLOC, 0, 32'h0, 1, 32'h0010_0000, STS_OK, 2);
      add_row(CMD_RUN, 3, 32'h0, 0, 32'h0, STS_OK, 0);
      add_row(CMD_FREE, 0, 32'h0010_1FFF, 0, 32'h0, STS_OK, 0);          // offset in page
      add_row(CMD_RUN, 2, 32'h0, 0, 32'h0, STS_OK, 0);                   // skips the hole
      add_row(CMD_ALLOC, 0, 32'h0, 0, 32'h0, STS_OK, 0);                 // fills the hole
      add_row(CMD_INIT, 8191, 32'hFFFF_FFFF, 1, 32'h0, STS_OK, 0);
      add_row(CMD_RUN, 3840, 32'h0, 1, 32'h0010_0000, STS_OK, 3840);     // whole map
      add_row(CMD_ALLOC, 0, 32'h0, 1, 32'h0, STS_NOMEM, 3840);           // full
      add_row(CMD_FREE, 0, 32'h00FF_F000, 0, 32'h0, STS_OK, 0);          // top frame
      add_row(CMD_RUN, 2, 32'h0, 0, 32'h0, STS_OK, 0);
      add_row(CMD_ALLOC, 0, 32'h0, 0, 32'h0, STS_OK, 0);
      add_row(CMD_INIT, 0, 32'h0, 1, 32'h0, STS_OK, 0);
      add_row(CMD_RUN, 4096, 32'h0, 1, 32'h0, STS_NOMEM, 0);
      add_row(CMD_RUN, 1, 32'h0, 1, 32'h0010_0000, STS_OK, 1);

      for (i = 0; i < directed_rows.size(); i++) begin
         send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
         pace_sender();
      end

      // random phases: extremes first, then small maps that fill up quickly
      run_phase(4096, 4096, 150, 0);     // full-size map, init marks everything
      run_phase(0, 0, 40, 0);            // no frames at all
      run_phase(64, 16, 400, 1);         // one word, long receiver hold-off
      run_phase(8191, 8191, 150, 0);     // both clamp to the map size
      run_phase(100, 200, 250, 0);       // reserved beyond count
      run_phase(1, 1, 60, 0);
      run_phase(3840, 0, 200, 0);
      run_phase(200, 0, 250, 0);         // shrink: stale bits above the count
      run_phase($urandom_range(1, 300), $urandom_range(0, 320), 100, 0);
      run_phase($urandom_range(1, 300), $urandom_range(0, 320), 100, 0);

      wait_drained();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### frame_bitmap_allocator.f
+incdir+sv
sv/fba_pkg.sv
sv/fba_map_ram.sv
sv/fba_run_find.sv
sv/frame_bitmap_allocator.sv
bench/frame_bitmap_allocator_tb.sv
